@@ rtl/core/bra_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_pkg
// Shared types and constants for the bitmap range allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int unsigned MapBitsDflt  = 4096;
  localparam int unsigned WordBitsDflt = 32;
  localparam int unsigned OpW          = 3;
  localparam int unsigned FirstW       = 12;
  localparam int unsigned CountW       = 13;
  localparam int unsigned SizeW        = 13;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned ValueW       = 12;
  localparam logic [SizeW-1:0] SizeRst = 13'd4096;

  typedef enum logic [OpW-1:0] {
    OP_FIND   = 3'd0,
    OP_ALLOC  = 3'd1,
    OP_ALLOCR = 3'd2,
    OP_TEST   = 3'd3,
    OP_SET    = 3'd4,
    OP_CLEAR  = 3'd5
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_ACCESS  = 2'd3
  } status_e;

endpackage

@@ rtl/core/bra_map_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_map_ram
// Single-port bitmap word store with a registered read.
// ----------------------------------------------------------------------------
module bra_map_ram #(
  parameter int unsigned Words = 128,
  parameter int unsigned Width = 32,
  localparam int unsigned AW = (Words > 1) ? $clog2(Words) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Words];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

@@ rtl/core/bitmap_range_allocator_core.sv @@
`timescale 1ns / 1ps
// Scans read each map word, then modify/write it, on the one RAM port.
// Clear pass after reset writes every map word to zero, input stalled meanwhile.
// One request at a time: no new request is accepted until its result is taken.
// Reset: asynchronous, active low; map all free, size = 4096.
// ----------------------------------------------------------------------------
// bitmap_range_allocator_core
// First-fit bitmap allocator with range set/clear/test over a word memory.
// ----------------------------------------------------------------------------
module bitmap_range_allocator_core
  import bra_pkg::*;
#(
  parameter int unsigned MAP_BITS  = MapBitsDflt,
  parameter int unsigned WORD_BITS = WordBitsDflt
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SizeW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [OpW-1:0]     operation_i,
  input  logic [FirstW-1:0]  first_bit_i,
  input  logic [CountW-1:0]  bit_count_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [StatusW-1:0] status_o,
  output logic [ValueW-1:0]  result_value_o
);

  localparam int unsigned Words = MAP_BITS / WORD_BITS;
  localparam int unsigned AW    = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned BW    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int unsigned XW    = 18; // bit positions up to MAP_BITS + count
  localparam logic [XW-1:0] MapBitsX = XW'(MAP_BITS);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_MOD, S_OUT} state_e;

  state_e             state_q;
  logic [AW-1:0]      clr_q;
  logic [SizeW-1:0]   size_reg_q;
  op_e                op_q;
  logic [XW-1:0]      lo_q, hi_q, wbase_q;
  logic [AW-1:0]      widx_q;
  logic [StatusW-1:0] st_q;
  logic [ValueW-1:0]  val_q;

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  // effective size: clip and round down to whole words
  logic [XW-1:0] size_x;
  always_comb begin
    size_x = (XW'(size_reg_q) > MapBitsX) ? MapBitsX : XW'(size_reg_q);
    size_x = XW'((size_x / WORD_BITS) * WORD_BITS);
  end

  // per-word mask of bits in [lo_q, hi_q)
  logic [WORD_BITS-1:0] rmask, free_bits, mod_word;
  logic                 found;
  logic [BW-1:0]        fpos;
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      rmask[i] = ((wbase_q + XW'(i)) >= lo_q) && ((wbase_q + XW'(i)) < hi_q);
    end
    free_bits = ~ram_rdata & rmask;
    found = |free_bits;
    fpos  = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) fpos = BW'(i);
    end
    case (op_q)
      OP_SET:   mod_word = ram_rdata | rmask;
      OP_CLEAR: mod_word = ram_rdata & ~rmask;
      default:  mod_word = ram_rdata | (WORD_BITS'(1) << fpos);
    endcase
  end

  logic last_word;
  assign last_word = (wbase_q + XW'(WORD_BITS)) >= hi_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = widx_q;
    ram_wdata = mod_word;
    if (state_q == S_CLR) begin
      ram_we    = 1'b1;
      ram_addr  = clr_q;
      ram_wdata = '0;
    end else if (state_q == S_MOD) begin
      case (op_q)
        OP_SET, OP_CLEAR: ram_we = 1'b1;
        OP_ALLOC, OP_ALLOCR: ram_we = found;
        default: ram_we = 1'b0;
      endcase
    end
  end

  bra_map_ram #(.Words(Words), .Width(WORD_BITS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  logic [XW-1:0] end_x;
  assign end_x = XW'(first_bit_i) + XW'(bit_count_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      clr_q      <= '0;
      size_reg_q <= SizeRst;
      op_q       <= OP_FIND;
      lo_q       <= '0;
      hi_q       <= '0;
      wbase_q    <= '0;
      widx_q     <= '0;
      st_q       <= ST_OK;
      val_q      <= '0;
    end else begin
      if (cfg_we_i) size_reg_q <= cfg_wdata_i;
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(Words - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            op_q  <= op_e'(operation_i);
            st_q  <= ST_OK;
            val_q <= '0;
            state_q <= S_OUT;
            if (operation_i == OP_FIND || operation_i == OP_ALLOC) begin
              lo_q <= '0;
              hi_q <= size_x;
              wbase_q <= '0;
              widx_q  <= '0;
              if (size_x == '0) st_q <= ST_NOSPACE;
              else state_q <= S_RD;
            end else if (operation_i == OP_ALLOCR || operation_i == OP_TEST ||
                         operation_i == OP_SET || operation_i == OP_CLEAR) begin
              lo_q <= XW'(first_bit_i);
              hi_q <= (end_x > size_x) ? size_x : end_x;
              wbase_q <= XW'((XW'(first_bit_i) / WORD_BITS) * WORD_BITS);
              widx_q  <= AW'(XW'(first_bit_i) / WORD_BITS);
              if (bit_count_i == '0) st_q <= ST_ILLEGAL;
              else if (XW'(first_bit_i) >= size_x)
                st_q <= (operation_i == OP_ALLOCR) ? ST_ILLEGAL : ST_ACCESS;
              else state_q <= S_RD;
            end else begin
              st_q <= ST_ILLEGAL;
            end
          end
        end
        S_RD: state_q <= S_MOD;
        S_MOD: begin
          state_q <= S_RD;
          widx_q  <= widx_q + AW'(1);
          wbase_q <= wbase_q + XW'(WORD_BITS);
          case (op_q)
            OP_TEST: begin
              if (|(ram_rdata & rmask)) begin
                val_q <= ValueW'(1);
                state_q <= S_OUT;
              end else if (last_word) state_q <= S_OUT;
            end
            OP_SET, OP_CLEAR: if (last_word) state_q <= S_OUT;
            default: begin
              if (found) begin
                val_q <= ValueW'(wbase_q + XW'(fpos));
                state_q <= S_OUT;
              end else if (last_word) begin
                st_q <= (op_q == OP_ALLOCR) ? ST_ACCESS : ST_NOSPACE;
                state_q <= S_OUT;
              end
            end
          endcase
        end
        S_OUT: if (!out_stall_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = (state_q == S_OUT);
  assign status_o       = st_q;
  assign result_value_o = (st_q == ST_OK) ? val_q : '0;

endmodule

@@ rtl/core/bra_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bra_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bra_checker
  import bra_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [StatusW-1:0] status_o,
  input logic [ValueW-1:0]  result_value_o
);

  // one word in flight: no new input while a result is pending
  a_no_accept_on_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");

  a_value_zero_on_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> result_value_o == '0)
    else $error("nonzero value on error status");

  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("not busy after accept");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
    && $stable(result_value_o)) else $error("stalled result changed");

endmodule

bind bitmap_range_allocator_core bra_checker u_bra_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .result_value_o (result_value_o)
);

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit bitmap allocator: a shadow bitmap
// predicts status and value of every request, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  import bra_pkg::*;

  localparam int unsigned NumWords = MapBitsDflt / WordBitsDflt;
  localparam int unsigned CycleLimit = 4000000;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ValueW-1:0]  value;
  } alloc_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [SizeW-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [OpW-1:0]     operation_i = '0;
  logic [FirstW-1:0]  first_bit_i = '0;
  logic [CountW-1:0]  bit_count_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [StatusW-1:0] status_o;
  logic [ValueW-1:0]  result_value_o;

  bitmap_range_allocator_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .operation_i(operation_i),
    .first_bit_i(first_bit_i), .bit_count_i(bit_count_i), .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i), .status_o(status_o), .result_value_o(result_value_o)
  );

  always #10 clk_i = ~clk_i;

  // shadow state
  logic [NumWords*WordBitsDflt-1:0] shadow_map = '0;
  logic [SizeW-1:0]                 shadow_size = SizeRst;
  alloc_res_t                       pending_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned n_items = 0;
  int unsigned n_checked = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  function automatic alloc_res_t predict_alloc(logic [OpW-1:0] op, logic [FirstW-1:0] first,
                                               logic [CountW-1:0] count);
    alloc_res_t r;
    int unsigned sz, last, b;
    bit found;
    r = '0;
    found = 1'b0;
    sz = shadow_size;
    if (sz > MapBitsDflt) sz = MapBitsDflt;
    sz = (sz / WordBitsDflt) * WordBitsDflt;
    if (op == OP_FIND || op == OP_ALLOC) begin
      for (b = 0; b < sz && !found; b++) begin
        if (!shadow_map[b]) begin
          found = 1'b1;
          r.value = b[ValueW-1:0];
          if (op == OP_ALLOC) shadow_map[b] = 1'b1;
        end
      end
      if (!found) r.status = ST_NOSPACE;
    end else if (op <= OP_CLEAR) begin
      if (count == 0) begin
        r.status = ST_ILLEGAL;
      end else if (first >= sz) begin
        r.status = (op == OP_ALLOCR) ? ST_ILLEGAL : ST_ACCESS;
      end else begin
        last = 32'(first) + 32'(count);
        if (last > sz) last = sz;
        for (b = first; b < last; b++) begin
          case (op)
            OP_ALLOCR: begin
              if (!found && !shadow_map[b]) begin
                found = 1'b1;
                shadow_map[b] = 1'b1;
                r.value = b[ValueW-1:0];
              end
            end
            OP_TEST: if (shadow_map[b]) r.value = ValueW'(1);
            OP_SET:  shadow_map[b] = 1'b1;
            default: shadow_map[b] = 1'b0;
          endcase
        end
        if (op == OP_ALLOCR && !found) r.status = ST_ACCESS;
      end
    end else begin
      r.status = ST_ILLEGAL;
    end
    return r;
  endfunction

  // valid stays high between back-to-back words; idle cycles and drain drop it
  task automatic send_req(logic [OpW-1:0] op, logic [FirstW-1:0] first,
                          logic [CountW-1:0] count);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    first_bit_i <= first;
    bit_count_i <= count;
    do @(posedge clk_i); while (in_stall_o);
    pending_q.push_back(predict_alloc(op, first, count));
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_size(logic [SizeW-1:0] sz);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= sz;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_size = sz;
  endtask

  // random receiver stall, changed at the falling edge
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk_i) begin
    alloc_res_t exp_r;
    cycles++;
    if (out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word status=%0d value=%0d", $time, status_o,
                 result_value_o);
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        n_checked++;
        if (status_o !== exp_r.status) begin
          $display("%0t: status exp %0d got %0d", $time, exp_r.status, status_o);
          errors++;
        end
        if (result_value_o !== exp_r.value) begin
          $display("%0t: value exp %0d got %0d", $time, exp_r.value, result_value_o);
          errors++;
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_directed;
    send_req(OP_FIND, 0, 0);
    send_req(OP_ALLOC, 0, 0);
    send_req(OP_ALLOC, 0, 0);
    send_req(OP_SET, 4095, 1);
    send_req(OP_TEST, 4095, 8191);
    send_req(OP_TEST, 100, 0);
    send_req(OP_SET, 0, 4096);
    send_req(OP_FIND, 0, 0);
    send_req(OP_ALLOCR, 10, 5);
    send_req(OP_CLEAR, 33, 2);
    send_req(OP_ALLOCR, 30, 8);
    send_req(OP_ALLOC, 0, 0);
    send_req(6, 0, 1);
    send_req(7, 4095, 8191);
    send_req(OP_CLEAR, 0, 8191);
    send_req(OP_TEST, 0, 4096);
    write_size(64);
    send_req(OP_ALLOCR, 64, 1);
    send_req(OP_TEST, 64, 1);
    send_req(OP_SET, 40, 4000);
    send_req(OP_ALLOC, 0, 0);
    write_size(0);
    send_req(OP_FIND, 0, 0);
    send_req(OP_SET, 0, 1);
    write_size(8191);
    send_req(OP_TEST, 0, 100);
    write_size(45);
    send_req(OP_TEST, 31, 20);
  endtask

  task automatic test_random(int unsigned n);
    logic [OpW-1:0] op;
    logic [FirstW-1:0] first;
    logic [CountW-1:0] count;
    for (int unsigned i = 0; i < n; i++) begin
      op = ($urandom_range(49) == 0) ? OpW'($urandom_range(7, 6)) : OpW'($urandom_range(5));
      case ($urandom_range(3))
        0: first = FirstW'($urandom);
        1: first = FirstW'($urandom_range(255));
        default: first = FirstW'($urandom_range(shadow_size > 4096 ? 4095 : shadow_size));
      endcase
      case ($urandom_range(4))
        0: count = CountW'($urandom);
        1: count = CountW'($urandom_range(1));
        default: count = CountW'($urandom_range(1, 96));
      endcase
      send_req(op, first, count);
    end
  endtask

  task automatic test_sizes;
    write_size(4096);
    test_random(300);
    write_size(512);
    test_random(300);
    write_size(SizeW'($urandom));
    test_random(150);
    write_size(32);
    test_random(150);
    write_size(4096);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 15;
    recv_idle_pct = 54;
    test_directed();
    test_sizes();
    send_idle_pct = 54;
    recv_idle_pct = 15;
    test_random(350);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(350);
    drain();
    if (pending_q.size() != 0) errors++;
    $display("Ran %0d requests (%0d checked) over all ops and map sizes 0..8191.",
             n_items, n_checked);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
